@@ hw/rtl/dhcpsel_pkg.sv @@
`default_nettype none

package dhcpsel_pkg;

    localparam logic [7:0]  OPT_PAD       = 8'd0;
    localparam logic [7:0]  OPT_END       = 8'd255;
    localparam logic [7:0]  OPT_MSG_TYPE  = 8'd53;
    localparam logic [7:0]  OPT_REQ_ADDR  = 8'd50;
    localparam logic [7:0]  REQ_ADDR_LEN  = 8'd4;
    localparam logic [7:0]  MSG_DISCOVER  = 8'd1;
    localparam logic [7:0]  MSG_REQUEST   = 8'd3;
    localparam logic [31:0] LEASE_RESET   = 32'hC0A8_0102;
    localparam logic [1:0]  VALUE_IDX_MAX = 2'd3;

    localparam logic [1:0] ACT_DROP = 2'd0;
    localparam logic [1:0] ACT_OFFER = 2'd1;
    localparam logic [1:0] ACT_ACK = 2'd2;

    typedef enum logic [3:0] {
        PH_CODE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_VAL  = 4'b0100,
        PH_STOP = 4'b1000
    } walk_phase_t;

    typedef struct packed {
        logic [7:0] option_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] your_address;
        logic [7:0]  seen_message_type;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/dhcpsel_walk.sv @@
`default_nettype none

module dhcpsel_walk (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire dhcpsel_pkg::item_t   item,
    input  wire logic [31:0]          lease_address,
    output dhcpsel_pkg::result_t      decision
);

    dhcpsel_pkg::walk_phase_t phase_reg, phase_next, phase_w;
    logic [7:0]  code_reg, code_next, code_w;
    logic [7:0]  remain_reg, remain_next, remain_w;
    logic [1:0]  index_reg, index_next, index_w;
    logic [7:0]  type_value_reg, type_value_next, type_value_w;
    logic        type_found_reg, type_found_next, type_found_w;
    logic [31:0] req_value_reg, req_value_next, req_value_w;
    logic        req_found_reg, req_found_next, req_found_w;

    always_comb
    begin
        phase_w      = phase_reg;
        code_w       = code_reg;
        remain_w     = remain_reg;
        index_w      = index_reg;
        type_value_w = type_value_reg;
        type_found_w = type_found_reg;
        req_value_w  = req_value_reg;
        req_found_w  = req_found_reg;
        case (phase_reg)
            dhcpsel_pkg::PH_CODE:
            begin
                if (item.option_byte == dhcpsel_pkg::OPT_END)
                begin
                    phase_w = dhcpsel_pkg::PH_STOP;
                end
                else if (item.option_byte != dhcpsel_pkg::OPT_PAD)
                begin
                    code_w  = item.option_byte;
                    phase_w = dhcpsel_pkg::PH_LEN;
                end
            end
            dhcpsel_pkg::PH_LEN:
            begin
                remain_w = item.option_byte;
                index_w  = 2'd0;
                if (code_reg == dhcpsel_pkg::OPT_MSG_TYPE)
                begin
                    if (type_found_reg)
                    begin
                        code_w = 8'd0;
                    end
                end
                else if (code_reg == dhcpsel_pkg::OPT_REQ_ADDR)
                begin
                    if (req_found_reg || item.option_byte != dhcpsel_pkg::REQ_ADDR_LEN)
                    begin
                        code_w = 8'd0;
                    end
                    else
                    begin
                        req_value_w = 32'd0;
                    end
                end
                else
                begin
                    code_w = 8'd0;
                end
                phase_w = (item.option_byte == 8'd0) ? dhcpsel_pkg::PH_CODE
                                                     : dhcpsel_pkg::PH_VAL;
            end
            dhcpsel_pkg::PH_VAL:
            begin
                if (code_reg == dhcpsel_pkg::OPT_MSG_TYPE && index_reg == 2'd0)
                begin
                    type_value_w = item.option_byte;
                    type_found_w = 1'b1;
                end
                else if (code_reg == dhcpsel_pkg::OPT_REQ_ADDR)
                begin
                    req_value_w = {req_value_reg[23:0], item.option_byte};
                    if (index_reg == dhcpsel_pkg::VALUE_IDX_MAX)
                    begin
                        req_found_w = 1'b1;
                    end
                end
                if (index_reg != dhcpsel_pkg::VALUE_IDX_MAX)
                begin
                    index_w = index_reg + 2'd1;
                end
                remain_w = remain_reg - 8'd1;
                if (remain_w == 8'd0)
                begin
                    phase_w = dhcpsel_pkg::PH_CODE;
                end
            end
            dhcpsel_pkg::PH_STOP:
            begin
                phase_w = dhcpsel_pkg::PH_STOP;
            end
            default:
            begin
                phase_w = dhcpsel_pkg::PH_CODE;
            end
        endcase
    end

    always_comb
    begin
        decision.action            = dhcpsel_pkg::ACT_DROP;
        decision.your_address      = 32'd0;
        decision.seen_message_type = type_found_w ? type_value_w : 8'd0;
        if (type_found_w && type_value_w == dhcpsel_pkg::MSG_DISCOVER)
        begin
            decision.action       = dhcpsel_pkg::ACT_OFFER;
            decision.your_address = lease_address;
        end
        else if (type_found_w && type_value_w == dhcpsel_pkg::MSG_REQUEST)
        begin
            decision.action       = dhcpsel_pkg::ACT_ACK;
            decision.your_address = (req_found_w && req_value_w != 32'd0) ? req_value_w
                                                                          : lease_address;
        end
    end

    // The field ends on the last byte, so the capture state starts over.
    always_comb
    begin
        if (item.last_byte)
        begin
            phase_next      = dhcpsel_pkg::PH_CODE;
            code_next       = 8'd0;
            remain_next     = 8'd0;
            index_next      = 2'd0;
            type_value_next = 8'd0;
            type_found_next = 1'b0;
            req_value_next  = 32'd0;
            req_found_next  = 1'b0;
        end
        else
        begin
            phase_next      = phase_w;
            code_next       = code_w;
            remain_next     = remain_w;
            index_next      = index_w;
            type_value_next = type_value_w;
            type_found_next = type_found_w;
            req_value_next  = req_value_w;
            req_found_next  = req_found_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= dhcpsel_pkg::PH_CODE;
            code_reg       <= 8'd0;
            remain_reg     <= 8'd0;
            index_reg      <= 2'd0;
            type_value_reg <= 8'd0;
            type_found_reg <= 1'b0;
            req_value_reg  <= 32'd0;
            req_found_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            code_reg       <= code_next;
            remain_reg     <= remain_next;
            index_reg      <= index_next;
            type_value_reg <= type_value_next;
            type_found_reg <= type_found_next;
            req_value_reg  <= req_value_next;
            req_found_reg  <= req_found_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dhcp_option_parse_reply_select.sv @@
// result_valid rises when the decision for the last byte loads the output register.
// Throughput: one byte per cycle unless stalled; the walk state updates once per byte.
// The input register stalls only while a finished result waits in the output register.
// Reset (rst_n, asynchronous, active low) clears the walk and capture state,
// empties both registers and loads lease_address with 192.168.1.2.
`default_nettype none

module dhcp_option_parse_reply_select (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire dhcpsel_pkg::item_t    item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output dhcpsel_pkg::result_t       result,
    input  wire logic                  cfg_write,
    input  wire logic [31:0]           cfg_data
);

    logic                  stage_valid_reg;
    dhcpsel_pkg::item_t    stage_reg;
    logic                  out_valid_reg;
    dhcpsel_pkg::result_t  out_reg;
    logic [31:0]           lease_reg;
    logic                  out_free;
    logic                  step;
    dhcpsel_pkg::result_t  decision;

    assign out_free     = !out_valid_reg || !result_stall;
    assign step         = stage_valid_reg && (!stage_reg.last_byte || out_free);
    assign item_stall   = stage_valid_reg && !step;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    dhcpsel_walk u_walk (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .item          (stage_reg),
        .lease_address (lease_reg),
        .decision      (decision)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lease_reg <= dhcpsel_pkg::LEASE_RESET;
        end
        else if (cfg_write)
        begin
            lease_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            stage_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            stage_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step && stage_reg.last_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && step && stage_reg.last_byte)
        begin
            out_reg <= decision;
        end
    end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import dhcpsel_pkg::*;

    localparam int LONG_HOLD = 80;
    localparam int STALL_LIMIT = 2000;

    typedef logic [7:0] byte_list_t[$];

    class reply_tracker;
        walk_phase_t phase;
        logic [7:0] code_now;
        logic [7:0] remaining;
        logic [1:0] pos;
        logic [7:0] type_byte;
        logic type_seen;
        logic [31:0] req_addr;
        logic addr_seen;
        logic [31:0] lease;
        result_t awaited_replies[$];
        int failures;

        function new();
            lease = LEASE_RESET;
            failures = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            phase = PH_CODE;
            code_now = '0;
            remaining = '0;
            pos = '0;
            type_byte = '0;
            type_seen = 1'b0;
            req_addr = '0;
            addr_seen = 1'b0;
        endfunction

        function void set_lease(logic [31:0] value);
            lease = value;
        endfunction

        function int pending();
            return awaited_replies.size();
        endfunction

        function void take_byte(item_t it);
            logic [7:0] b;
            result_t r;
            b = it.option_byte;
            case (phase)
                PH_CODE:
                begin
                    if (b == OPT_END)
                        phase = PH_STOP;
                    else if (b != OPT_PAD)
                    begin
                        code_now = b;
                        phase = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    remaining = b;
                    pos = '0;
                    if (code_now == OPT_MSG_TYPE)
                    begin
                        if (type_seen)
                            code_now = '0;
                    end
                    else if (code_now == OPT_REQ_ADDR)
                    begin
                        if (addr_seen || b != REQ_ADDR_LEN)
                            code_now = '0;
                        else
                            req_addr = '0;
                    end
                    else
                        code_now = '0;
                    phase = (b == 8'd0) ? PH_CODE : PH_VAL;
                end
                PH_VAL:
                begin
                    if (code_now == OPT_MSG_TYPE && pos == 2'd0)
                    begin
                        type_byte = b;
                        type_seen = 1'b1;
                    end
                    else if (code_now == OPT_REQ_ADDR)
                    begin
                        req_addr = {req_addr[23:0], b};
                        if (pos == VALUE_IDX_MAX)
                            addr_seen = 1'b1;
                    end
                    if (pos != VALUE_IDX_MAX)
                        pos = pos + 2'd1;
                    remaining = remaining - 8'd1;
                    if (remaining == 8'd0)
                        phase = PH_CODE;
                end
                default:
                begin
                end
            endcase
            if (it.last_byte)
            begin
                r.action = ACT_DROP;
                r.your_address = '0;
                if (type_seen && type_byte == MSG_DISCOVER)
                begin
                    r.action = ACT_OFFER;
                    r.your_address = lease;
                end
                else if (type_seen && type_byte == MSG_REQUEST)
                begin
                    r.action = ACT_ACK;
                    r.your_address = (addr_seen && req_addr != '0) ? req_addr : lease;
                end
                r.seen_message_type = type_seen ? type_byte : '0;
                awaited_replies.push_back(r);
                clear_walk();
            end
        endfunction

        function void check_reply(result_t got);
            result_t want;
            if (awaited_replies.size() == 0)
            begin
                $error("unexpected reply: action %0d, address %h, message type %0d",
                       got.action, got.your_address, got.seen_message_type);
                failures++;
                return;
            end
            want = awaited_replies.pop_front();
            if (got.action !== want.action)
            begin
                $error("action: expected %0d, actual %0d", want.action, got.action);
                failures++;
            end
            if (got.your_address !== want.your_address)
            begin
                $error("your_address: expected %h, actual %h",
                       want.your_address, got.your_address);
                failures++;
            end
            if (got.seen_message_type !== want.seen_message_type)
            begin
                $error("seen_message_type: expected %0d, actual %0d",
                       want.seen_message_type, got.seen_message_type);
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    item_t item;
    logic result_valid;
    logic result_stall;
    result_t result;
    logic cfg_write;
    logic [31:0] cfg_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    reply_tracker tracker = new();

    dhcp_option_parse_reply_select DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served <= hold_requests;
            hold_left <= LONG_HOLD;
            result_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            tracker.take_byte(item);
        if (rst_n && result_valid && !result_stall)
            tracker.check_reply(result);
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        item_t nxt;
        nxt.option_byte = b;
        nxt.last_byte = is_last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= nxt;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    task automatic send_field(input byte_list_t f);
        for (int i = 0; i < f.size(); i++)
            send_byte(f[i], i == f.size() - 1);
    endtask

    task automatic settle(input int extra);
        item_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_lease(input logic [31:0] value);
        settle(4);
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        tracker.set_lease(value);
    endtask

    function automatic byte_list_t random_field();
        byte_list_t f;
        int records;
        int len;
        int keep;
        logic [7:0] v;
        logic zero_addr;
        f = {};
        if ($urandom_range(9) == 0)
        begin
            len = $urandom_range(1, 8);
            repeat (len)
            begin
                v = 8'($urandom_range(255));
                f.push_back(v);
            end
            return f;
        end
        records = $urandom_range(1, 4);
        repeat (records)
        begin
            case ($urandom_range(9))
                0:
                    f.push_back(OPT_PAD);
                1, 2, 3:
                begin
                    len = ($urandom_range(3) == 0) ? $urandom_range(0, 3) : 1;
                    f.push_back(OPT_MSG_TYPE);
                    f.push_back(len[7:0]);
                    for (int i = 0; i < len; i++)
                    begin
                        case ($urandom_range(5))
                            0, 1: v = MSG_DISCOVER;
                            2, 3: v = MSG_REQUEST;
                            4: v = 8'd0;
                            default: v = 8'($urandom_range(255));
                        endcase
                        f.push_back(v);
                    end
                end
                4, 5, 6:
                begin
                    len = ($urandom_range(3) == 0) ? $urandom_range(0, 6) : 4;
                    zero_addr = ($urandom_range(3) == 0);
                    f.push_back(OPT_REQ_ADDR);
                    f.push_back(len[7:0]);
                    repeat (len)
                    begin
                        v = zero_addr ? 8'd0 : 8'($urandom_range(255));
                        f.push_back(v);
                    end
                end
                7, 8:
                begin
                    v = 8'($urandom_range(1, 254));
                    len = $urandom_range(0, 5);
                    f.push_back(v);
                    f.push_back(len[7:0]);
                    repeat (len)
                    begin
                        v = 8'($urandom_range(255));
                        f.push_back(v);
                    end
                end
                default:
                begin
                    f.push_back(OPT_END);
                    repeat ($urandom_range(0, 3))
                    begin
                        v = 8'($urandom_range(255));
                        f.push_back(v);
                    end
                end
            endcase
        end
        if ($urandom_range(7) == 0 && f.size() > 1)
        begin
            keep = $urandom_range(1, f.size() - 1);
            while (f.size() > keep)
                void'(f.pop_back());
        end
        return f;
    endfunction

    task automatic run_random(input int budget, input bit with_pressure);
        byte_list_t f;
        int sent;
        bit held;
        bit paused;
        sent = 0;
        held = 1'b0;
        paused = 1'b0;
        while (sent < budget)
        begin
            f = random_field();
            send_field(f);
            sent += f.size();
            if (with_pressure && !held && sent >= budget / 4)
            begin
                hold_requests <= hold_requests + 1;
                held = 1'b1;
            end
            else if (with_pressure && !paused && sent >= budget / 2)
            begin
                settle(1);
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        byte_list_t f;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 34;
        recv_idle_pct = 55;
        f = {OPT_MSG_TYPE, 8'd1, MSG_DISCOVER};
        send_field(f);
        f = {OPT_REQ_ADDR, REQ_ADDR_LEN, 8'hFF, 8'h00, 8'h80, 8'h01,
             OPT_MSG_TYPE, 8'd1, MSG_REQUEST};
        send_field(f);
        f = {OPT_MSG_TYPE};
        send_field(f);
        f = {OPT_END, OPT_MSG_TYPE, 8'd1, MSG_DISCOVER};
        send_field(f);
        f = {OPT_MSG_TYPE, 8'd2, MSG_REQUEST};
        send_field(f);
        f = {OPT_MSG_TYPE, 8'd0, OPT_MSG_TYPE, 8'd1, 8'd0, OPT_MSG_TYPE};
        send_field(f);

        write_lease(32'h0000_0000);
        run_random(140, 1'b0);

        write_lease(32'hFFFF_FFFF);
        send_idle_pct = 55;
        recv_idle_pct = 34;
        run_random(140, 1'b0);

        write_lease($urandom);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(170, 1'b1);

        settle(8);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
